### design/locale_record_stream_parser_assert.svh
// Assertion macros shared by the parser modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef LOCALE_RECORD_STREAM_PARSER_ASSERT_SVH
`define LOCALE_RECORD_STREAM_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked while out of reset only
`define LRSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define LRSP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define LRSP_ASSERT(name, prop, msg)
`define LRSP_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

### design/lrsp_pkg.sv
package lrsp_pkg;

  // Parser phase within a record
  typedef enum logic [1:0] {
    PH_CAT  = 2'd0,
    PH_NAME = 2'd1,
    PH_TEXT = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  // Kind of an output word
  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_FILE   = 2'd3
  } kind_e;

  // Record-end status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CLEAN     = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_KEY_LONG  = 3'd3,
    ST_UNTERM    = 3'd4,
    ST_TEXT_LONG = 3'd5
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_KEY_LIMIT  = 1'b0,
    CFG_TEXT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    status_e     status;
  } item_t;

  // Zero, one or two results produced by one input byte
  typedef struct packed {
    logic [1:0] n;
    item_t      item0;
    item_t      item1;
  } res_push_t;

  localparam logic [15:0] UNIT_LF   = 16'h0a00;
  localparam logic [15:0] UNIT_CR   = 16'h0d00;
  localparam logic [7:0]  TOKEN_END = 8'h20;
  localparam logic [7:0]  KEY_SEP   = 8'h2e;
  localparam logic [9:0]  LEN_MAX   = 10'd1023;
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  localparam logic [9:0]  KEY_LIMIT_RST  = 10'd152;
  localparam logic [15:0] TEXT_LIMIT_RST = 16'd2048;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

endpackage

### design/lrsp_parse.sv
module lrsp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_data_i,
  input  logic                in_last_i,
  input  logic [9:0]          key_limit_i,
  input  logic [15:0]         text_limit_i,
  input  logic                room_i,
  output lrsp_pkg::res_push_t push_o
);
  import lrsp_pkg::*;

  `include "locale_record_stream_parser_assert.svh"

  logic        in_valid_q;
  logic [7:0]  in_data_q;
  logic        in_last_q;
  logic        consume;

  phase_e      phase_q, phase_d;
  logic [9:0]  cat_len_q, cat_len_d;
  logic [9:0]  name_len_q, name_len_d;
  logic        nul_q, nul_d;
  logic [7:0]  low_hold_q, low_hold_d;
  logic        parity_q, parity_d;
  logic [15:0] prev_unit_q, prev_unit_d;
  logic        prev_valid_q, prev_valid_d;
  logic [15:0] text_cnt_q, text_cnt_d;
  logic        text_stop_q, text_stop_d;

  logic        main_vld;
  item_t       main_item;
  item_t       file_item;
  logic [15:0] unit;
  logic [11:0] key_sum;
  logic        is_term;

  // Input register: takes a new word whenever the held one moves on
  assign consume    = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
      in_last_q <= in_last_i;
    end
  end

  assign unit      = {in_data_q, low_hold_q};
  assign key_sum   = {2'b00, cat_len_q} + {2'b00, name_len_q} + 12'd2;
  assign is_term   = prev_valid_q && (prev_unit_q == UNIT_LF) && (unit == UNIT_CR);
  assign file_item = '{kind: KIND_FILE, value: 16'h0000, status: ST_OK};

  // Per-byte decision and next state
  always_comb begin
    phase_d      = phase_q;
    cat_len_d    = cat_len_q;
    name_len_d   = name_len_q;
    nul_d        = nul_q;
    low_hold_d   = low_hold_q;
    parity_d     = parity_q;
    prev_unit_d  = prev_unit_q;
    prev_valid_d = prev_valid_q;
    text_cnt_d   = text_cnt_q;
    text_stop_d  = text_stop_q;
    main_vld     = 1'b0;
    main_item    = '{kind: KIND_KEY, value: 16'h0000, status: ST_OK};

    if (consume) begin
      unique case (phase_q)
        PH_CAT: begin
          if (in_last_q) begin
            main_vld  = 1'b1;
            main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_CLEAN};
          end else if (in_data_q == TOKEN_END) begin
            main_vld  = 1'b1;
            main_item = '{kind: KIND_KEY, value: {8'h00, KEY_SEP}, status: ST_OK};
            phase_d   = PH_NAME;
            nul_d     = 1'b0;
          end else begin
            if (cat_len_q != LEN_MAX) cat_len_d = cat_len_q + 10'd1;
            if (in_data_q == 8'h00) nul_d = 1'b1;
            if (!nul_q && in_data_q != 8'h00) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_KEY, value: {8'h00, in_data_q}, status: ST_OK};
            end
          end
        end
        PH_NAME: begin
          if (in_data_q == TOKEN_END) begin
            if (key_sum > {2'b00, key_limit_i}) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_KEY_LONG};
              phase_d   = PH_ERR;
            end else if (in_last_q) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_UNTERM};
              phase_d   = PH_ERR;
            end else begin
              phase_d      = PH_TEXT;
              low_hold_d   = 8'h00;
              parity_d     = 1'b0;
              prev_unit_d  = 16'h0000;
              prev_valid_d = 1'b0;
              text_cnt_d   = 16'h0000;
              text_stop_d  = 1'b0;
            end
          end else if (in_last_q) begin
            main_vld  = 1'b1;
            main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_TRUNC};
            phase_d   = PH_ERR;
          end else begin
            if (name_len_q != LEN_MAX) name_len_d = name_len_q + 10'd1;
            if (in_data_q == 8'h00) nul_d = 1'b1;
            if (!nul_q && in_data_q != 8'h00) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_KEY, value: {8'h00, in_data_q}, status: ST_OK};
            end
          end
        end
        PH_TEXT: begin
          if (!parity_q) begin
            // low byte of a unit
            low_hold_d = in_data_q;
            parity_d   = 1'b1;
            if (in_last_q) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_UNTERM};
              phase_d   = PH_ERR;
            end
          end else begin
            parity_d = 1'b0;
            if (is_term) begin
              main_vld = 1'b1;
              if (text_cnt_q == COUNT_MAX || text_cnt_q > text_limit_i) begin
                main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_TEXT_LONG};
                phase_d   = PH_ERR;
              end else begin
                main_item    = '{kind: KIND_RECORD, value: 16'h0000, status: ST_OK};
                phase_d      = PH_CAT;
                cat_len_d    = 10'd0;
                name_len_d   = 10'd0;
                nul_d        = 1'b0;
                low_hold_d   = 8'h00;
                prev_unit_d  = 16'h0000;
                prev_valid_d = 1'b0;
                text_cnt_d   = 16'h0000;
                text_stop_d  = 1'b0;
              end
            end else if (in_last_q) begin
              main_vld  = 1'b1;
              main_item = '{kind: KIND_RECORD, value: 16'h0000, status: ST_UNTERM};
              phase_d   = PH_ERR;
            end else begin
              // the previous unit goes out one unit late
              if (prev_valid_q) begin
                text_cnt_d = (text_cnt_q >= COUNT_MAX - 16'd1) ? COUNT_MAX
                                                                : text_cnt_q + 16'd2;
                if (prev_unit_q == 16'h0000) text_stop_d = 1'b1;
                if (!text_stop_q && prev_unit_q != 16'h0000) begin
                  main_vld  = 1'b1;
                  main_item = '{kind: KIND_TEXT, value: prev_unit_q, status: ST_OK};
                end
              end
              prev_unit_d  = unit;
              prev_valid_d = 1'b1;
            end
          end
        end
        PH_ERR: begin
        end
        default: begin
        end
      endcase

      // end of file resets everything but the limits
      if (in_last_q) begin
        phase_d      = PH_CAT;
        cat_len_d    = 10'd0;
        name_len_d   = 10'd0;
        nul_d        = 1'b0;
        low_hold_d   = 8'h00;
        parity_d     = 1'b0;
        prev_unit_d  = 16'h0000;
        prev_valid_d = 1'b0;
        text_cnt_d   = 16'h0000;
        text_stop_d  = 1'b0;
      end
    end
  end

  // Results to the queue: the main word first, file end after it
  always_comb begin
    push_o.item0 = main_item;
    push_o.item1 = file_item;
    push_o.n     = 2'd0;
    if (consume) begin
      if (in_last_q) begin
        if (main_vld) begin
          push_o.n = 2'd2;
        end else begin
          push_o.item0 = file_item;
          push_o.n     = 2'd1;
        end
      end else if (main_vld) begin
        push_o.n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CAT;
      cat_len_q    <= 10'd0;
      name_len_q   <= 10'd0;
      nul_q        <= 1'b0;
      low_hold_q   <= 8'h00;
      parity_q     <= 1'b0;
      prev_unit_q  <= 16'h0000;
      prev_valid_q <= 1'b0;
      text_cnt_q   <= 16'h0000;
      text_stop_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cat_len_q    <= cat_len_d;
      name_len_q   <= name_len_d;
      nul_q        <= nul_d;
      low_hold_q   <= low_hold_d;
      parity_q     <= parity_d;
      prev_unit_q  <= prev_unit_d;
      prev_valid_q <= prev_valid_d;
      text_cnt_q   <= text_cnt_d;
      text_stop_q  <= text_stop_d;
    end
  end

  `LRSP_ASSERT(a_file_end_on_last, (push_o.n != 2'd0 && push_o.item0.kind == KIND_FILE) |-> (consume && in_last_q), "file end without last byte")
  `LRSP_ASSERT(a_last_restarts, (consume && in_last_q) |=> (phase_q == PH_CAT && !prev_valid_q && !parity_q), "state not cleared after file end")
  `LRSP_ASSERT(a_two_only_on_last, (push_o.n == 2'd2) |-> (in_last_q && push_o.item1.kind == KIND_FILE && push_o.item0.kind == KIND_RECORD), "two results without record and file end")

endmodule

### design/lrsp_res_fifo.sv
module lrsp_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrsp_pkg::res_push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrsp_pkg::item_t     out_item_o
);
  import lrsp_pkg::*;

  `include "locale_record_stream_parser_assert.svh"

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  // Room for a worst-case pair of results
  assign room_o      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d    = cnt_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.item0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.item1;
  end

  `LRSP_ASSERT(a_push_has_room, (push_i.n != 2'd0) |-> room_o, "push without room")
  `LRSP_ASSERT(a_cnt_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `LRSP_ASSERT_ALWAYS(a_empty_after_reset, !rst_ni |=> cnt_q == '0, "queue not empty after reset")

endmodule

### design/locale_record_stream_parser.sv
// Locale table parser: takes a table file one byte per word on the slave
// stream (tlast on the final byte) and emits key bytes, 16-bit text units,
// record-end words with a status and a file-end word on the master stream.
// It sustains one input byte per cycle. A byte is accepted into an input
// register, decided once the result queue has room and its results written
// to that four-word queue, from which the master side takes them. The final
// byte of a file produces a file-end word, after a record-end word unless the
// record already ended in error, while the master side takes one word per
// cycle. Input therefore stalls when the master side holds back, or when
// final bytes follow each other faster than the queue drains. The user must
// write limits on the cfg port while the block idles; it is not enforced.
module locale_record_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] item_value, [18:16] item_status, rest 0
  output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import lrsp_pkg::*;

  logic [9:0]  key_limit_q;
  logic [15:0] text_limit_q;
  logic        room;
  res_push_t   push;
  item_t       out_item;

  // Limit registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q  <= KEY_LIMIT_RST;
      text_limit_q <= TEXT_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_LIMIT:  key_limit_q  <= cfg_data_i[9:0];
        CFG_TEXT_LIMIT: text_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lrsp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .key_limit_i  (key_limit_q),
    .text_limit_i (text_limit_q),
    .room_i       (room),
    .push_o       (push)
  );

  lrsp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {5'b00000, out_item.status, out_item.value};
  assign m_axis_tuser = out_item.kind;

endmodule

### bench/locale_record_stream_parser_checker.sv
// Watches the byte, result and register channels of the parser, keeps its own
// copy of the parser state and compares every result word with the oldest
// prediction.
module locale_record_stream_parser_checker
  import lrsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic [1:0]  out_user_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the limit registers
  logic [9:0]  key_limit;
  logic [15:0] text_limit;

  // shadow of the parse state
  phase_e      parse_phase;
  logic [9:0]  cat_len;
  logic [9:0]  name_len;
  logic        nul_seen;
  logic [7:0]  low_hold;
  logic        odd_byte;
  logic [15:0] prev_unit;
  logic        prev_valid;
  logic [15:0] text_count;
  logic        text_stopped;

  item_t       expected_words[$];
  int          mismatches = 0;

  task automatic add_expected(input kind_e kind, input logic [15:0] value,
                              input status_e status);
    item_t w;
    w.kind   = kind;
    w.value  = value;
    w.status = status;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic clear_text();
    low_hold     = '0;
    odd_byte     = 1'b0;
    prev_unit    = '0;
    prev_valid   = 1'b0;
    text_count   = '0;
    text_stopped = 1'b0;
  endtask

  task automatic clear_record();
    parse_phase = PH_CAT;
    cat_len     = '0;
    name_len    = '0;
    nul_seen    = 1'b0;
    clear_text();
  endtask

  task automatic enter_error(input status_e status);
    parse_phase = PH_ERR;
    add_expected(KIND_RECORD, '0, status);
  endtask

  // token byte: nothing is emitted from the first NUL to the token end
  task automatic take_key_byte(input logic [7:0] b);
    if (b == 8'h00) nul_seen = 1'b1;
    if (!nul_seen) add_expected(KIND_KEY, {8'h00, b}, ST_OK);
  endtask

  // predict the words caused by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    case (parse_phase)
      PH_CAT: begin
        if (last) begin
          add_expected(KIND_RECORD, '0, ST_CLEAN);
        end else if (b == TOKEN_END) begin
          add_expected(KIND_KEY, {8'h00, KEY_SEP}, ST_OK);
          parse_phase = PH_NAME;
          nul_seen    = 1'b0;
        end else begin
          if (cat_len != LEN_MAX) cat_len++;
          take_key_byte(b);
        end
      end
      PH_NAME: begin
        if (b == TOKEN_END) begin
          if (int'(cat_len) + int'(name_len) + 2 > int'(key_limit)) begin
            enter_error(ST_KEY_LONG);
          end else if (last) begin
            enter_error(ST_UNTERM);
          end else begin
            parse_phase = PH_TEXT;
            clear_text();
          end
        end else if (last) begin
          enter_error(ST_TRUNC);
        end else begin
          if (name_len != LEN_MAX) name_len++;
          take_key_byte(b);
        end
      end
      PH_TEXT: begin
        if (!odd_byte) begin
          low_hold = b;
          odd_byte = 1'b1;
          if (last) enter_error(ST_UNTERM);
        end else begin
          odd_byte = 1'b0;
          unit     = {b, low_hold};
          if (prev_valid && prev_unit == UNIT_LF && unit == UNIT_CR) begin
            if (text_count == COUNT_MAX || text_count > text_limit) begin
              enter_error(ST_TEXT_LONG);
            end else begin
              add_expected(KIND_RECORD, '0, ST_OK);
              clear_record();
            end
          end else if (last) begin
            enter_error(ST_UNTERM);
          end else begin
            // units go out one late, so the one before the terminator never does
            if (prev_valid) begin
              text_count = (text_count >= COUNT_MAX - 16'd1) ? COUNT_MAX
                                                             : text_count + 16'd2;
              if (prev_unit == 16'h0000) text_stopped = 1'b1;
              if (!text_stopped) add_expected(KIND_TEXT, prev_unit, ST_OK);
            end
            prev_unit  = unit;
            prev_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      add_expected(KIND_FILE, '0, ST_OK);
      clear_record();
    end
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t want;
    if (!rst_ni) begin
      key_limit  = KEY_LIMIT_RST;
      text_limit = TEXT_LIMIT_RST;
      clear_record();
      expected_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_KEY_LIMIT) key_limit = cfg_data_i[9:0];
        else                              text_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) parse_byte(in_data_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d value %h status %0d",
                 out_user_i, out_data_i[15:0], out_data_i[18:16]);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_user_i != want.kind) begin
            $error("item_kind mismatch: expected %0d, got %0d", want.kind, out_user_i);
            mismatches++;
          end
          if (out_data_i[15:0] != want.value) begin
            $error("item_value mismatch: expected %h, got %h", want.value,
                   out_data_i[15:0]);
            mismatches++;
          end
          if (out_data_i[18:16] != want.status) begin
            $error("item_status mismatch: expected %0d, got %0d", want.status,
                   out_data_i[18:16]);
            mismatches++;
          end
          if (out_data_i[23:19] != 5'd0) begin
            $error("tdata pad mismatch: expected 0, got %h", out_data_i[23:19]);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
    end
  end

endmodule

### bench/locale_record_stream_parser_tb.sv
module locale_record_stream_parser_tb;
  import lrsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 220;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [15:0] item_value, [18:16] item_status
  logic [1:0]  m_axis_tuser;         // [1:0] item_kind
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [15:0] cfg_data_i    = '0;

  int          fail_count;
  int          pending;
  bit          src_idle_en   = 1'b1;
  bit          sink_idle_en  = 1'b1;
  int          sent_bytes    = 0;
  logic [7:0]  file_bytes[$];

  locale_record_stream_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  locale_record_stream_parser_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 13);
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    while (src_idle_en && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  // send the assembled bytes; tlast on the final one when closing the file
  task automatic send_file(input logic with_last);
    foreach (file_bytes[i])
      send_byte(file_bytes[i], with_last && (i == file_bytes.size() - 1));
    file_bytes.delete();
  endtask

  // stop sending and let every predicted word come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both limits back to back, valid held across the two words
  task automatic set_limits(input logic [15:0] key_word, input logic [15:0] text_word);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_KEY_LIMIT;
    cfg_data_i  <= key_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_TEXT_LIMIT;
    cfg_data_i  <= text_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_unit();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return UNIT_LF;
    if (pick == 2) return UNIT_CR;
    return 16'($urandom_range(16'hffff));
  endfunction

  // append one byte to the file being assembled
  task automatic add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic push_unit(input logic [15:0] unit);
    add_byte(unit[7:0]);
    add_byte(unit[15:8]);
  endtask

  // token bytes never hold a space; some are NUL
  task automatic push_token(input int len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(255));
      if (b == TOKEN_END) b = 8'h5f;
      if ($urandom_range(9) == 0) b = 8'h00;
      add_byte(b);
    end
  endtask

  task automatic push_record(input int max_tok, input int max_units);
    push_token($urandom_range(max_tok));
    add_byte(TOKEN_END);
    push_token($urandom_range(max_tok));
    add_byte(TOKEN_END);
    repeat ($urandom_range(max_units)) push_unit(random_unit());
    push_unit(UNIT_LF);
    push_unit(UNIT_CR);
  endtask

  // mostly well-formed files; some cut short, some plain noise
  task automatic send_random_file();
    int pick;
    int cut;
    pick = $urandom_range(19);
    if (pick == 0) begin
      repeat ($urandom_range(1, 24))
        add_byte(($urandom_range(2) == 0) ? TOKEN_END : 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) push_record(6, 10);
      if (pick < 14) begin
        add_byte(8'($urandom_range(255)));
      end else begin
        cut = $urandom_range(1, file_bytes.size());
        file_bytes = file_bytes[0:cut-1];
      end
    end
    send_file(1'b1);
  endtask

  initial begin
    int          p;
    int          target;
    int          guard;
    logic [15:0] key_word;
    logic [15:0] text_word;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // clean stop on the very first byte
    file_bytes = '{8'hff};
    send_file(1'b1);
    // NUL cuts the category; file ends inside the name
    file_bytes = '{8'h63, 8'h00, 8'h64, TOKEN_END, 8'h6e, 8'h7a};
    send_file(1'b1);
    // empty key, unit ffff, zero unit stops emission; pause mid-text
    file_bytes = '{TOKEN_END, TOKEN_END, 8'hff, 8'hff, 8'h00, 8'h00};
    send_file(1'b0);
    wait_drained();
    file_bytes = '{8'h41, 8'h00, 8'h00, 8'h0a, 8'h00, 8'h0d, TOKEN_END};
    send_file(1'b1);
    // name space as final byte, then an odd text byte as final byte
    file_bytes = '{TOKEN_END, TOKEN_END};
    send_file(1'b1);
    file_bytes = '{TOKEN_END, TOKEN_END, 8'h01};
    send_file(1'b1);

    // lowest limits: key too long, text too long, ignored bytes
    set_limits(16'd2, 16'd0);
    file_bytes = '{8'h61, TOKEN_END, TOKEN_END, 8'h71, 8'h72};
    send_file(1'b1);
    file_bytes = '{8'h61, TOKEN_END, TOKEN_END};
    send_file(1'b1);
    file_bytes = '{TOKEN_END, TOKEN_END, 8'h00, 8'h0a, 8'h00, 8'h0d,
                   TOKEN_END, TOKEN_END, 8'h41, 8'h00, 8'h00, 8'h0a, 8'h00, 8'h0d,
                   8'h07};
    send_file(1'b1);

    // random phases, each under its own limits
    for (p = 0; p < 6; p++) begin
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
      case (p)
        0: begin
          key_word  = {6'($urandom_range(63)), KEY_LIMIT_RST};
          text_word = TEXT_LIMIT_RST;
        end
        1: begin
          key_word  = {6'($urandom_range(63)), 10'd1023};
          text_word = 16'hffff;
        end
        2: begin
          key_word     = {6'($urandom_range(63)), 10'($urandom_range(2, 16))};
          text_word    = 16'($urandom_range(20));
          src_idle_en  = 1'b0;
          sink_idle_en = 1'b0;
        end
        4: begin
          key_word  = 16'($urandom_range(16'hffff));
          text_word = 16'($urandom_range(16'hffff));
        end
        5: begin
          key_word  = {6'($urandom_range(63)), 10'($urandom_range(2, 5))};
          text_word = 16'($urandom_range(4));
        end
        default: begin
          key_word  = {6'($urandom_range(63)), 10'($urandom_range(2, 16))};
          text_word = 16'($urandom_range(20));
        end
      endcase
      set_limits(key_word, text_word);
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) send_random_file();
    end

    // drain, bounded
    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
